// ----- rtl/c8_pkg.sv -----
// c8_pkg: shared types and constants for the chip-8 instruction core
// no dependencies
`default_nettype none
package c8_pkg;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_CLEAR   = 3'd1;
    localparam logic [2:0] ST_DRAW    = 3'd2;
    localparam logic [2:0] ST_UNIMPL  = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;
    localparam logic [2:0] ST_WAIT    = 3'd5;

    localparam logic [7:0] LO_CLS   = 8'hE0;
    localparam logic [7:0] LO_RET   = 8'hEE;
    localparam logic [7:0] LO_SKP   = 8'h9E;
    localparam logic [7:0] LO_SKNP  = 8'hA1;
    localparam logic [7:0] LO_GDT   = 8'h07;
    localparam logic [7:0] LO_SDT   = 8'h15;
    localparam logic [7:0] LO_SST   = 8'h18;
    localparam logic [7:0] LO_ADDI  = 8'h1E;
    localparam logic [7:0] LO_WKEY  = 8'h0A;
    localparam logic [7:0] LO_FONT  = 8'h29;
    localparam logic [7:0] LO_BCD   = 8'h33;
    localparam logic [7:0] LO_STORE = 8'h55;
    localparam logic [7:0] LO_LOAD  = 8'h65;

    typedef struct packed {
        logic       kind;
        logic [11:0] address;
        logic [7:0]  data;
        logic [7:0]  random_byte;
    } c8_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic [15:0] instruction_word;
    } c8_out_t;

    // what the datapath does this cycle
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,   // latch input item
        CMD_WRITE,     // ram write of the load item
        CMD_RD_HI,     // read pc
        CMD_RD_LO,     // read pc+1, latch hi
        CMD_LATCH_LO,  // latch lo
        CMD_EXEC,      // execute the fetched instruction
        CMD_BLK_WR,    // one step of a store (bcd or block)
        CMD_BLK_RD,    // issue read for block load
        CMD_BLK_LD,    // latch loaded byte into vreg
        CMD_RESULT     // finish result register
    } c8_cmd_e;

    typedef struct packed {
        c8_cmd_e    op;
        logic [3:0] step;
    } c8_cmd_t;

    typedef struct packed {
        logic       kind;
        logic       is_store;   // fx55
        logic       is_bcd;     // fx33
        logic       is_load;    // fx65
        logic [3:0] last_k;     // x nibble, or 2 for fx33
    } c8_stat_t;

endpackage
`default_nettype wire

// ----- rtl/c8_if.sv -----
// c8_if: valid/ready channel carrying one payload
// depends on nothing
`default_nettype none
interface c8_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/c8_datapath.sv -----
// c8_datapath: ram, register file, pc, stack and instruction execution
// depends on c8_pkg
`default_nettype none
module c8_datapath
    import c8_pkg::*;
#(
    parameter int MEM_BYTES     = 4096,
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512,
    parameter int FONT_BASE     = 80,
    parameter int GLYPH_BYTES   = 5
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire c8_in_t  in_item,
    input  wire c8_cmd_t cmd,
    output c8_stat_t     stat,
    output c8_out_t      result
);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [11:0] PC_RST = 12'(PROGRAM_START);
    localparam logic [11:0] FB     = 12'(FONT_BASE);
    localparam logic [11:0] GB     = 12'(GLYPH_BYTES);

    logic [7:0]  mem [MEM_BYTES];
    logic [7:0]  rd_data_reg;
    logic [7:0]  vregs_reg [16];
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [11:0] pc_reg, index_reg;
    logic [SW-1:0] sp_reg;
    c8_in_t      item_reg;
    logic [7:0]  hi_reg, lo_reg;
    c8_out_t     result_reg;

    // addresses wrap to 12 bits then to memory size
    function automatic logic [AW-1:0] slot(input logic [11:0] a);
        return AW'({20'd0, a} % MEM_BYTES);
    endfunction

    logic [3:0]  op, x, y, n;
    logic [7:0]  vx, vy;
    logic [11:0] nnn, pc2, pc4;
    assign op  = hi_reg[7:4];
    assign x   = hi_reg[3:0];
    assign y   = lo_reg[7:4];
    assign n   = lo_reg[3:0];
    assign vx  = vregs_reg[x];
    assign vy  = vregs_reg[y];
    assign nnn = {x, lo_reg};
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;

    // stack pointer steps, wrapping at the stack depth
    logic [SW-1:0] sp_dec, sp_inc;
    assign sp_dec = (sp_reg == '0) ? SW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign sp_inc = (sp_reg == SW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;

    // bcd digits, vx below 256; tens by reciprocal multiply, exact below 100
    logic [7:0]  hund, rem1, tens, ones;
    logic [15:0] tens_mul;
    always_comb
    begin
        hund     = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
        rem1     = vx - 8'(hund * 8'd100);
        tens_mul = {8'd0, rem1} * 16'd205;
        tens     = {3'd0, tens_mul[15:11]};
        ones     = rem1 - 8'(tens * 8'd10);
    end

    logic [7:0]  st_byte;
    logic [11:0] st_addr;
    always_comb
    begin
        st_addr = index_reg + {8'd0, cmd.step};
        if (stat.is_bcd)
        begin
            st_byte = (cmd.step == 4'd0) ? hund : (cmd.step == 4'd1) ? tens : ones;
        end
        else
        begin
            st_byte = vregs_reg[cmd.step];
        end
    end

    // memory: one write, one registered read
    logic [11:0] rd_addr;
    always_comb
    begin
        unique case (cmd.op)
            CMD_RD_HI:  rd_addr = pc_reg;
            CMD_RD_LO:  rd_addr = pc_reg + 12'd1;
            default:    rd_addr = st_addr;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_WRITE)
        begin
            mem[slot(item_reg.address)] <= item_reg.data;
        end
        else if (cmd.op == CMD_BLK_WR)
        begin
            mem[slot(st_addr)] <= st_byte;
        end
        rd_data_reg <= mem[slot(rd_addr)];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_CAPTURE)
        begin
            item_reg <= in_item;
        end
        if (cmd.op == CMD_RD_LO)
        begin
            hi_reg <= rd_data_reg;
        end
        if (cmd.op == CMD_LATCH_LO)
        begin
            lo_reg <= rd_data_reg;
        end
    end

    logic [7:0] alu_r;
    logic       alu_f, alu_wf;
    always_comb
    begin
        alu_f  = 1'b0;
        alu_wf = 1'b1;
        unique case (n)
            4'h0: begin alu_r = vy;      alu_wf = 1'b0; end
            4'h1: begin alu_r = vx | vy; alu_wf = 1'b0; end
            4'h2: begin alu_r = vx & vy; alu_wf = 1'b0; end
            4'h3: begin alu_r = vx ^ vy; alu_wf = 1'b0; end
            4'h4: {alu_f, alu_r} = {1'b0, vx} + {1'b0, vy};
            4'h5: begin alu_r = vx - vy; alu_f = vx > vy; end
            4'h6: begin alu_r = vx >> 1; alu_f = vx[0]; end
            4'h7: begin alu_r = vy - vx; alu_f = vy > vx; end
            4'hE: begin alu_r = vx << 1; alu_f = vx[7]; end
            default: begin alu_r = vx; alu_wf = 1'b0; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg    <= PC_RST;
            index_reg <= 12'd0;
            sp_reg    <= '0;
            for (int i = 0; i < 16; i++) vregs_reg[i] <= 8'd0;
            for (int i = 0; i < STACK_DEPTH; i++) stack_reg[i] <= 12'd0;
            result_reg <= '0;
        end
        else
        begin
            unique case (cmd.op)
                CMD_WRITE:
                begin
                    result_reg <= '{ST_DONE, pc_reg, index_reg, 8'd0, 8'd0, 4'd0, 16'd0};
                end
                CMD_BLK_LD:
                begin
                    vregs_reg[cmd.step] <= rd_data_reg;
                end
                CMD_RESULT:
                begin
                    result_reg.program_counter <= pc_reg;
                    result_reg.index_value     <= index_reg;
                end
                CMD_EXEC:
                begin
                    logic [2:0]  st;
                    logic [11:0] nx;
                    st = ST_DONE;
                    nx = pc2;
                    if (hi_reg == 8'h00 && lo_reg == LO_CLS)
                    begin
                        st = ST_CLEAR;
                    end
                    else if (hi_reg == 8'h00 && lo_reg == LO_RET)
                    begin
                        sp_reg <= sp_dec;
                        nx = stack_reg[sp_dec] + 12'd2;
                    end
                    else if (op == 4'h0)
                    begin
                        st = ST_DONE;
                    end
                    else if (op == 4'h1)
                    begin
                        nx = nnn;
                    end
                    else if (op == 4'h2)
                    begin
                        stack_reg[sp_reg] <= pc_reg;
                        sp_reg <= sp_inc;
                        nx = nnn;
                    end
                    else if (op == 4'h3)
                    begin
                        if (vx == lo_reg) nx = pc4;
                    end
                    else if (op == 4'h4)
                    begin
                        if (vx != lo_reg) nx = pc4;
                    end
                    else if (op == 4'h5 && n == 4'h0)
                    begin
                        if (vx == vy) nx = pc4;
                    end
                    else if (op == 4'h6)
                    begin
                        vregs_reg[x] <= lo_reg;
                    end
                    else if (op == 4'h7)
                    begin
                        vregs_reg[x] <= vx + lo_reg;
                    end
                    else if (op == 4'h8 && (n <= 4'h7 || n == 4'hE))
                    begin
                        // the flag wins over the result when x is vf
                        if (alu_wf)
                        begin
                            vregs_reg[15] <= {7'd0, alu_f};
                            if (x != 4'hF) vregs_reg[x] <= alu_r;
                        end
                        else
                        begin
                            vregs_reg[x] <= alu_r;
                        end
                    end
                    else if (op == 4'h9 && n == 4'h0)
                    begin
                        if (vx != vy) nx = pc4;
                    end
                    else if (op == 4'hA)
                    begin
                        index_reg <= nnn;
                    end
                    else if (op == 4'hB)
                    begin
                        nx = {4'd0, vregs_reg[0]} + nnn;
                    end
                    else if (op == 4'hC)
                    begin
                        vregs_reg[x] <= item_reg.random_byte & lo_reg;
                    end
                    else if (op == 4'hD)
                    begin
                        st = ST_DRAW;
                    end
                    else if (op == 4'hE && (lo_reg == LO_SKP || lo_reg == LO_SKNP))
                    begin
                        st = ST_UNIMPL;
                    end
                    else if (op == 4'hF && (lo_reg == LO_GDT || lo_reg == LO_SDT
                             || lo_reg == LO_SST || lo_reg == LO_ADDI))
                    begin
                        st = ST_UNIMPL;
                    end
                    else if (op == 4'hF && lo_reg == LO_WKEY)
                    begin
                        st = ST_WAIT;
                        nx = pc_reg;
                    end
                    else if (op == 4'hF && lo_reg == LO_FONT)
                    begin
                        index_reg <= FB + 12'({4'd0, vx} * GB);
                    end
                    else if (op == 4'hF && (lo_reg == LO_BCD || lo_reg == LO_STORE
                             || lo_reg == LO_LOAD))
                    begin
                        st = ST_DONE;
                    end
                    else
                    begin
                        st = ST_INVALID;
                    end
                    pc_reg <= nx;
                    result_reg.status           <= st;
                    result_reg.draw_x           <= (st == ST_DRAW) ? vx : 8'd0;
                    result_reg.draw_y           <= (st == ST_DRAW) ? vy : 8'd0;
                    result_reg.draw_rows        <= (st == ST_DRAW) ? n : 4'd0;
                    result_reg.instruction_word <= {hi_reg, lo_reg};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.kind     = item_reg.kind;
    assign stat.is_store = (op == 4'hF) && (lo_reg == LO_STORE);
    assign stat.is_bcd   = (op == 4'hF) && (lo_reg == LO_BCD);
    assign stat.is_load  = (op == 4'hF) && (lo_reg == LO_LOAD);
    assign stat.last_k   = stat.is_bcd ? 4'd2 : x;
    assign result        = result_reg;

`ifndef SYNTHESIS
    a_rst_pc: assert property (@(posedge clk) $rose(rst_n) |-> pc_reg == PC_RST)
        else $error("pc not at program start after reset");
    a_wait_pc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == CMD_EXEC && op == 4'hF && lo_reg == LO_WKEY |=> $stable(pc_reg))
        else $error("wait key moved pc");
    a_store_keeps_i: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == CMD_BLK_WR |=> $stable(index_reg))
        else $error("block store changed i");
`endif
endmodule
`default_nettype wire

// ----- rtl/c8_control.sv -----
// c8_control: sequencer for fetch, execute, block transfers and result handshake
// depends on c8_pkg
`default_nettype none
module c8_control
    import c8_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire c8_stat_t stat,
    output c8_cmd_t       cmd
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DEC   = 10'b0000000010,
        S_RDHI  = 10'b0000000100,
        S_RDLO  = 10'b0000001000,
        S_LATLO = 10'b0000010000,
        S_EXEC  = 10'b0000100000,
        S_BWR   = 10'b0001000000,
        S_BRD   = 10'b0010000000,
        S_BLD   = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] k_reg, k_next;
    logic       ov_reg, ov_next;

    // a finished result may wait in the output register while idle
    assign in_ready  = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ov_next    = ov_reg && !out_ready;
        cmd.op     = CMD_NONE;
        cmd.step   = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.op     = CMD_CAPTURE;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!stat.kind)
                begin
                    cmd.op     = CMD_WRITE;
                    state_next = S_IDLE;
                    ov_next    = 1'b1;
                end
                else
                begin
                    state_next = S_RDHI;
                end
            end
            S_RDHI:  begin cmd.op = CMD_RD_HI;    state_next = S_RDLO; end
            S_RDLO:  begin cmd.op = CMD_RD_LO;    state_next = S_LATLO; end
            S_LATLO: begin cmd.op = CMD_LATCH_LO; state_next = S_EXEC; end
            S_EXEC:
            begin
                cmd.op = CMD_EXEC;
                k_next = 4'd0;
                priority if (stat.is_store || stat.is_bcd) state_next = S_BWR;
                else if (stat.is_load)                    state_next = S_BRD;
                else                                      state_next = S_FIN;
            end
            S_BWR:
            begin
                cmd.op = CMD_BLK_WR;
                k_next = k_reg + 4'd1;
                if (k_reg == stat.last_k) state_next = S_FIN;
            end
            S_BRD:   begin cmd.op = CMD_BLK_RD; state_next = S_BLD; end
            S_BLD:
            begin
                cmd.op = CMD_BLK_LD;
                k_next = k_reg + 4'd1;
                state_next = (k_reg == stat.last_k) ? S_FIN : S_BRD;
            end
            S_FIN:
            begin
                cmd.op     = CMD_RESULT;
                state_next = S_IDLE;
                ov_next    = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= 4'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

`ifndef SYNTHESIS
    a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FIN |=> out_valid)
        else $error("no result after finish");
`endif
endmodule
`default_nettype wire

// ----- rtl/chip8_instruction_core.sv -----
// chip8_instruction_core: top level, joins the sequencer and the datapath
// depends on c8_pkg, c8_if, c8_control, c8_datapath
//
// usage: the in channel carries one item per transaction; kind 0 writes one ram
// byte (program and font loading), kind 1 executes the instruction at pc.
// every item yields exactly one result transaction on the out channel.
// flow: a write item's result is valid once the byte is written; an instruction
// is fetched by two registered ram reads, then executed; fx33 then writes three
// digits and fx55 writes x+1 bytes through the one ram write port, in turn;
// fx65 loads x+1 bytes, one ram read and one register load per byte.
// one item at a time: no new item is taken until the result of the last one
// is taken.
// the result waits in an output register; the next item is accepted as soon as
// that result is taken, or in the same cycle it is taken.
// reset puts pc at the program start and clears v registers, i, sp and stack;
// ram contents are left undefined until written.
`default_nettype none
module chip8_instruction_core
    import c8_pkg::*;
#(
    parameter int MEM_BYTES     = 4096,
    parameter int STACK_DEPTH   = 16,
    parameter int PROGRAM_START = 512,
    parameter int FONT_BASE     = 80,
    parameter int GLYPH_BYTES   = 5
) (
    input wire logic clk,
    input wire logic rst_n,
    c8_if.sink       in_ch,
    c8_if.source     out_ch
);
    c8_cmd_t  cmd;
    c8_stat_t stat;
    c8_out_t  result;

    c8_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    c8_datapath #(
        .MEM_BYTES     (MEM_BYTES),
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_START (PROGRAM_START),
        .FONT_BASE     (FONT_BASE),
        .GLYPH_BYTES   (GLYPH_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_ch.payload),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result)
    );

    assign out_ch.payload = result;
endmodule
`default_nettype wire
